// ===== sv/ovn2d_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and the cosine weight function for the octave value noise block
// depends on nothing; used by every module of the block
package ovn2d_pkg;

    // sizes of the block
    localparam int COORD_BITS  = 8;
    localparam int MAX_OCTAVES = 8;
    localparam int WEIGHT_BITS = 16;

    // derived widths
    localparam int W_W    = WEIGHT_BITS + 1;      // weight 0 .. 2^WEIGHT_BITS
    localparam int V_W    = 36;                   // biased smoothed value, 0 .. 2^35
    localparam int SIG_W  = 36;                   // signed octave sample, scale 2^34
    localparam int AMP_W  = 17;                   // amplitude, Q16, up to 1.0
    localparam int ACC_W  = SIG_W + AMP_W + 5;    // weighted sum of all octaves
    localparam int NGRP   = (MAX_OCTAVES + 3) / 4;
    localparam int OUT_W  = 20;
    localparam int CFG_W  = 32;
    localparam int PIPE_N = 12;                   // valid stages before the output register

    // constants of the hash and the fixed-point formats
    localparam logic [31:0] HASH_MUL_Y  = 32'd97171;
    localparam logic [31:0] HASH_MUL_SQ = 32'd15731;
    localparam logic [31:0] HASH_ADD    = 32'd1376312589;
    localparam logic [31:0] LAT_ONE     = 32'h4000_0000;
    localparam logic [V_W-1:0] SMOOTH_BIAS = V_W'(64'd1 << 34);
    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
    localparam int FRAC_SHIFT = 34;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd524287;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd524288;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HASH_SEED    = 2'd0,
        REG_OCTAVE_COUNT = 2'd1,
        REG_PERSISTENCE  = 2'd2
    } cfg_reg_t;

    typedef logic signed [SIG_W-1:0] sig_t;
    typedef logic [W_W-1:0] weight_t;
    typedef logic [COORD_BITS-1:0] coord_t;

    // cosine blend weight for fraction k / 2^b, evaluated only on constants
    function automatic weight_t cos_weight(input logic [31:0] k, input int b);
        logic [63:0] full;
        logic        fold;
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] w30;
        logic [63:0] w;
        full = 64'd1 << b;
        fold = 64'(k) > (full >> 1);
        kk = fold ? full - 64'(k) : 64'(k);
        x = (kk * 64'd3373259426) >> b;
        u = (x * x) >> 30;
        t = 64'd1073741824;
        t = 64'd1073741824 - ((u * t) >> 30) / 64'd132;
        t = 64'd1073741824 - ((u * t) >> 30) / 64'd90;
        t = 64'd1073741824 - ((u * t) >> 30) / 64'd56;
        t = 64'd1073741824 - ((u * t) >> 30) / 64'd30;
        t = 64'd1073741824 - ((u * t) >> 30) / 64'd12;
        w30 = ((u * t) >> 30) / 64'd4;
        if (w30 > 64'd536870912)
        begin
            w30 = 64'd536870912;
        end
        w = (w30 + (64'd1 << (29 - WEIGHT_BITS))) >> (30 - WEIGHT_BITS);
        if (fold)
        begin
            w = (64'd1 << WEIGHT_BITS) - w;
        end
        return W_W'(w);
    endfunction

endpackage

// ===== sv/octave_value_noise_2d.sv =====
`timescale 1ns / 1ps
// top level of the octave value noise block: registers, amplitudes, octave sum, output skid
// depends on ovn2d_pkg and ovn2d_lanes
//
// One coordinate pair in, one noise sample out, one transfer per clock when neither side
// stalls. An item passes through these stages before it reaches the output register
// (input register, five hash stages, smoothing, two blend stages, amplitude multiply and a
// two-level octave sum); every octave has its own lane of 16 hash units, so the rate does
// not depend on octave_count. A skid register behind the output register lets the pipeline
// finish one more transfer after out_stall rises. The amplitude of each octave comes from a
// chain of registered multipliers, so a write to persistence_reg must ripple down the chain
// to settle; this is covered by the pipeline depth for an item accepted after the write.
module octave_value_noise_2d
    import ovn2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [COORD_BITS-1:0]   coord_x,
    input  logic [COORD_BITS-1:0]   coord_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] noise_value
);

    logic [31:0]             hash_seed_reg;
    logic [3:0]              octave_count_reg;
    logic [7:0]              persistence_reg;
    logic [AMP_W-1:0]        amp_reg [MAX_OCTAVES];
    logic                    en;
    logic [PIPE_N-1:0]       v_reg;
    coord_t                  cx_reg;
    coord_t                  cy_reg;
    sig_t                    sig [MAX_OCTAVES];
    logic [3:0]              n_eff;
    logic signed [ACC_W-1:0] prod_reg [MAX_OCTAVES];
    logic signed [ACC_W-1:0] grp_next [NGRP];
    logic signed [ACC_W-1:0] grp_reg [NGRP];
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-FRAC_SHIFT-1:0] q_full;
    logic signed [OUT_W-1:0] q_next;
    logic signed [OUT_W-1:0] q_reg;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_data_reg;
    logic                    skid_valid_reg;
    logic signed [OUT_W-1:0] skid_data_reg;
    logic                    arrive;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg    <= 32'd789221;
            octave_count_reg <= 4'd4;
            persistence_reg  <= 8'd128;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HASH_SEED:    hash_seed_reg    <= cfg_data[31:0];
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                REG_PERSISTENCE:  persistence_reg  <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // amplitude chain, one registered multiply per octave after the first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_OCTAVES; i++)
            begin
                amp_reg[i] <= AMP_W'(AMP_ONE >> i);
            end
        end
        else
        begin
            amp_reg[0] <= AMP_ONE;
            for (int i = 1; i < MAX_OCTAVES; i++)
            begin
                amp_reg[i] <= AMP_W'(((AMP_W+8)'(amp_reg[i-1]) * (AMP_W+8)'(persistence_reg)) >> 8);
            end
        end
    end

    // the pipeline moves whenever the skid register is empty
    assign en = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_N-2:0], in_valid};
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= coord_x;
            cy_reg <= coord_y;
        end
    end

    ovn2d_lanes u_lanes (
        .clk  (clk),
        .en   (en),
        .seed (hash_seed_reg),
        .cx   (cx_reg),
        .cy   (cy_reg),
        .sig  (sig)
    );

    // octaves beyond the configured count contribute nothing
    assign n_eff = (octave_count_reg > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octave_count_reg;

    // group sums of up to four weighted octaves
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int m = 0; m < 4; m++)
            begin
                if (4 * g + m < MAX_OCTAVES)
                begin
                    grp_next[g] = grp_next[g] + prod_reg[4 * g + m];
                end
            end
        end
    end

    // final sum, floor to Q16 and saturate
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + grp_reg[g];
        end
        q_full = total[ACC_W-1:FRAC_SHIFT];
        if (q_full > (ACC_W-FRAC_SHIFT)'(OUT_MAX))
        begin
            q_next = OUT_MAX;
        end
        else if (q_full < (ACC_W-FRAC_SHIFT)'(OUT_MIN))
        begin
            q_next = OUT_MIN;
        end
        else
        begin
            q_next = q_full[OUT_W-1:0];
        end
    end

    // amplitude multiply, group sum, final sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < MAX_OCTAVES; i++)
            begin
                if (4'(i) < n_eff)
                begin
                    prod_reg[i] <= ACC_W'(sig[i]) * ACC_W'($signed({1'b0, amp_reg[i]}));
                end
                else
                begin
                    prod_reg[i] <= '0;
                end
            end
            grp_reg <= grp_next;
            q_reg   <= q_next;
        end
    end

    assign arrive = en && v_reg[PIPE_N-1];

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= arrive;
            end
        end
        else if (arrive)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : q_reg;
        end
        else if (arrive)
        begin
            skid_data_reg <= q_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = out_data_reg;

    // the skid register only holds a sample while the output register holds one too
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // the skid register fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid register filled without a stalled output");

    // a frozen pipeline keeps its valid bits
    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved while frozen");

    // draining the skid register keeps a sample on the output
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> out_valid_reg && !skid_valid_reg)
        else $error("skid register did not drain into the output register");

endmodule

// ===== sv/ovn2d_hash.sv =====
`timescale 1ns / 1ps
// five-stage pipelined seeded integer hash of one lattice point, giving 1 - h/2^30 in Q30
// depends on ovn2d_pkg
module ovn2d_hash
    import ovn2d_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        seed,
    input  logic [31:0]        px,
    input  logic [31:0]        py,
    output logic signed [31:0] lat
);

    logic [31:0] n0;
    logic [31:0] n1_next;
    logic [31:0] n1_reg;
    logic [31:0] sq_reg;
    logic [31:0] n1_d2_reg;
    logic [31:0] pp_reg;
    logic [31:0] n1_d3_reg;
    logic [31:0] m_reg;
    logic [31:0] h;
    logic signed [31:0] lat_reg;

    // mix the coordinates; add and mask the final product
    always_comb
    begin
        n0 = px + py * HASH_MUL_Y;
        n1_next = (n0 << 13) ^ n0;
        h = (m_reg + HASH_ADD) & 32'h7fff_ffff;
    end

    // square, polynomial term, final product, lattice value
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= n1_next;
            sq_reg    <= n1_reg * n1_reg;
            n1_d2_reg <= n1_reg;
            pp_reg    <= sq_reg * HASH_MUL_SQ + seed;
            n1_d3_reg <= n1_d2_reg;
            m_reg     <= n1_d3_reg * pp_reg;
            lat_reg   <= $signed(LAT_ONE - h);
        end
    end

    assign lat = lat_reg;

endmodule

// ===== sv/ovn2d_lanes.sv =====
`timescale 1ns / 1ps
// one lane per octave: 4x4 lattice hashes, 3x3 smoothing, cosine blend in x then y
// depends on ovn2d_pkg and ovn2d_hash
module ovn2d_lanes
    import ovn2d_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] seed,
    input  coord_t      cx,
    input  coord_t      cy,
    output sig_t        sig [MAX_OCTAVES]
);

    // interpolate between a and b: (a*(1-w) + b*w) >> WEIGHT_BITS, a and b unsigned
    function automatic logic [V_W-1:0] blend(input logic [V_W-1:0] a,
                                             input logic [V_W-1:0] b,
                                             input weight_t w);
        localparam int BL_W = V_W + WEIGHT_BITS + 2;
        logic signed [V_W:0]    d;
        logic signed [BL_W-1:0] p;
        logic signed [BL_W-1:0] num;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = BL_W'(d) * BL_W'($signed({1'b0, w}));
        num = $signed(BL_W'({a, {WEIGHT_BITS{1'b0}}})) + p;
        return num[WEIGHT_BITS +: V_W];
    endfunction

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_lane
        localparam int B  = i + 2;
        localparam int FB = (B < COORD_BITS) ? B : COORD_BITS;

        logic [31:0]        gx;
        logic [31:0]        gy;
        logic signed [31:0] lat [4][4];
        weight_t            wtab [2**FB];
        weight_t            wx_reg [7];
        weight_t            wy_reg [7];
        logic [V_W-1:0]     vb_next [2][2];
        logic [V_W-1:0]     vb_reg [2][2];
        logic [V_W-1:0]     r1_reg;
        logic [V_W-1:0]     r2_reg;
        logic [V_W-1:0]     res;
        sig_t               sig_reg;

        // cell of this octave
        assign gx = 32'(cx >> B);
        assign gy = 32'(cy >> B);

        // lattice hashes over cells -1 .. +2 in each direction, wrapping at zero
        for (genvar j = 0; j < 4; j++)
        begin : g_col
            for (genvar k = 0; k < 4; k++)
            begin : g_row
                ovn2d_hash u_hash (
                    .clk  (clk),
                    .en   (en),
                    .seed (seed),
                    .px   (gx + 32'(j) - 32'd1),
                    .py   (gy + 32'(k) - 32'd1),
                    .lat  (lat[j][k])
                );
            end
        end

        // weight table of this octave, fixed at elaboration
        for (genvar kk = 0; kk < 2**FB; kk++)
        begin : g_wtab
            assign wtab[kk] = cos_weight(32'(kk), B);
        end

        // weights travel alongside the hash pipeline
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                wx_reg[0] <= wtab[cx[FB-1:0]];
                wy_reg[0] <= wtab[cy[FB-1:0]];
                for (int s = 1; s < 7; s++)
                begin
                    wx_reg[s] <= wx_reg[s-1];
                    wy_reg[s] <= wy_reg[s-1];
                end
            end
        end

        // smoothing: corners 1/16, sides 1/8, centre 1/4, then biased positive
        always_comb
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int b = 0; b < 2; b++)
                begin
                    vb_next[a][b] = V_W'(
                          SIG_W'(lat[a][b])     + SIG_W'(lat[a+2][b])
                        + SIG_W'(lat[a][b+2])   + SIG_W'(lat[a+2][b+2])
                        + ((SIG_W'(lat[a][b+1])   + SIG_W'(lat[a+2][b+1])
                          + SIG_W'(lat[a+1][b])   + SIG_W'(lat[a+1][b+2])) <<< 1)
                        + (SIG_W'(lat[a+1][b+1]) <<< 2))
                        + SMOOTH_BIAS;
                end
            end
        end

        assign res = blend(r1_reg, r2_reg, wy_reg[6]);

        // smoothed corners, blend in x, blend in y
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vb_reg  <= vb_next;
                r1_reg  <= blend(vb_reg[0][0], vb_reg[1][0], wx_reg[5]);
                r2_reg  <= blend(vb_reg[0][1], vb_reg[1][1], wx_reg[5]);
                sig_reg <= $signed(res - SMOOTH_BIAS);
            end
        end

        assign sig[i] = sig_reg;
    end

endmodule

// ===== bench/octave_value_noise_2d_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for octave_value_noise_2d: directed and random coordinate transfers
// depends on ovn2d_pkg and the octave_value_noise_2d rtl; carries its own noise predictor
module octave_value_noise_2d_tb;
    import ovn2d_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [COORD_BITS-1:0] coord_x = '0;
    logic [COORD_BITS-1:0] coord_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] noise_value;

    // predictor copy of the registers
    logic [31:0] seed_q = 32'd789221;
    logic [3:0] octaves_q = 4'd4;
    logic [7:0] persist_q = 8'd128;

    logic signed [OUT_W-1:0] pending_noise[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int quiet_cycles = 0;
    bit running = 1'b0;

    octave_value_noise_2d dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .coord_x(coord_x), .coord_y(coord_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .noise_value(noise_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // seeded integer hash mapped to 2^30 - h
    function automatic longint lattice_val(logic [31:0] x, logic [31:0] y);
        logic [31:0] n;
        logic [31:0] h;
        longint hl;
        n = x + y * 32'd97171;
        n = (n << 13) ^ n;
        h = (n * (n * n * 32'd15731 + seed_q) + 32'd1376312589) & 32'h7fff_ffff;
        hl = 64'(h);
        return 64'sd1073741824 - hl;
    endfunction

    // 3x3 smoothing, biased by 2^34
    function automatic logic [63:0] smooth_biased(logic [31:0] x, logic [31:0] y);
        longint c;
        longint s;
        c = lattice_val(x - 1, y - 1) + lattice_val(x + 1, y - 1)
          + lattice_val(x - 1, y + 1) + lattice_val(x + 1, y + 1);
        s = lattice_val(x - 1, y) + lattice_val(x + 1, y)
          + lattice_val(x, y - 1) + lattice_val(x, y + 1);
        return 64'(c + 2 * s + 4 * lattice_val(x, y) + (64'sd1 <<< 34));
    endfunction

    // cosine blend weight for fraction k / 2^b
    function automatic logic [63:0] blend_weight(logic [31:0] k, int b);
        logic [63:0] full;
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] w;
        logic [63:0] divs[5];
        bit folded;
        divs = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
        full = 64'd1 << b;
        folded = 64'(k) > (full >> 1);
        kk = folded ? full - 64'(k) : 64'(k);
        x = (kk * 64'd3373259426) >> b;
        u = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
        begin
            t = (64'd1 << 30) - ((u * t) >> 30) / divs[i];
        end
        w = ((u * t) >> 30) / 64'd4;
        if (w > (64'd1 << 29))
        begin
            w = 64'd1 << 29;
        end
        w = (w + (64'd1 << (29 - WEIGHT_BITS))) >> (30 - WEIGHT_BITS);
        return folded ? (64'd1 << WEIGHT_BITS) - w : w;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * ((64'd1 << WEIGHT_BITS) - w) + b * w) >> WEIGHT_BITS;
    endfunction

    // summed octave noise at one grid point, saturated Q4.16
    function automatic logic signed [OUT_W-1:0] predict_noise(logic [31:0] cx,
                                                              logic [31:0] cy);
        int n_oct;
        int b;
        longint amp;
        longint total;
        longint sig;
        longint q;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [63:0] wx;
        logic [63:0] wy;
        logic [63:0] r1;
        logic [63:0] r2;
        n_oct = (octaves_q > MAX_OCTAVES) ? MAX_OCTAVES : octaves_q;
        amp = 65536;
        total = 0;
        for (int i = 0; i < n_oct; i++)
        begin
            b = i + 2;
            gx = cx >> b;
            gy = cy >> b;
            wx = blend_weight(cx & ((32'd1 << b) - 1), b);
            wy = blend_weight(cy & ((32'd1 << b) - 1), b);
            r1 = mix(smooth_biased(gx, gy), smooth_biased(gx + 1, gy), wx);
            r2 = mix(smooth_biased(gx, gy + 1), smooth_biased(gx + 1, gy + 1), wx);
            sig = longint'(mix(r1, r2, wy)) - (64'sd1 <<< 34);
            total += sig * amp;
            amp = (amp * persist_q) >>> 8;
        end
        q = total >>> 34;
        if (q > 524287)
        begin
            q = 524287;
        end
        if (q < -524288)
        begin
            q = -524288;
        end
        return q[OUT_W-1:0];
    endfunction

    // receiver stall, result check and watchdog
    always @(posedge clk)
    begin
        logic signed [OUT_W-1:0] want;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (running)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("octave_value_noise_2d verification failed");
                $finish;
            end
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_noise.size() == 0)
            begin
                $error("noise_value: no result expected, actual %0d", noise_value);
                error_count++;
            end
            else
            begin
                want = pending_noise.pop_front();
                checked_count++;
                if (noise_value !== want)
                begin
                    $error("noise_value: expected %0d, actual %0d", want, noise_value);
                    error_count++;
                end
            end
        end
    end

    // one coordinate transfer, then idle cycles drawn one per cycle
    task automatic send_coord(logic [7:0] x, logic [7:0] y);
        in_valid <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        do
            @(posedge clk);
        while (in_stall);
        pending_noise.push_back(predict_noise(32'(x), 32'(y)));
        sent_count++;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_noise.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_HASH_SEED:    seed_q = val;
            REG_OCTAVE_COUNT: octaves_q = val[3:0];
            REG_PERSISTENCE:  persist_q = val[7:0];
            default:          ;
        endcase
        repeat (8) @(posedge clk);
    endtask

    task automatic test_corners;
        send_coord(8'd0, 8'd0);
        send_coord(8'd255, 8'd255);
        send_coord(8'd0, 8'd255);
        send_coord(8'd255, 8'd0);
        send_coord(8'd1, 8'd2);
    endtask

    task automatic test_octave_counts;
        logic [3:0] counts[5];
        counts = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15};
        foreach (counts[i])
        begin
            write_reg(REG_OCTAVE_COUNT, {28'd0, counts[i]});
            send_coord(8'd0, 8'd0);
            send_coord(8'd255, 8'd129);
        end
    endtask

    task automatic test_persistence_and_seed;
        write_reg(REG_PERSISTENCE, 32'd0);
        send_coord(8'd77, 8'd200);
        write_reg(REG_PERSISTENCE, 32'd255);
        send_coord(8'd77, 8'd200);
        write_reg(REG_HASH_SEED, 32'd0);
        send_coord(8'd0, 8'd3);
        write_reg(REG_HASH_SEED, 32'hffff_ffff);
        send_coord(8'd254, 8'd1);
        // unmapped register index must change nothing
        write_reg(REG_UNMAPPED, 32'hdead_beef);
        send_coord(8'd254, 8'd1);
    endtask

    task automatic test_random(int pct_in, int pct_out);
        drain();
        idle_pct = pct_in;
        stall_pct = pct_out;
        for (int c = 0; c < 3; c++)
        begin
            write_reg(REG_HASH_SEED, $urandom);
            write_reg(REG_OCTAVE_COUNT, $urandom_range(15));
            write_reg(REG_PERSISTENCE, $urandom_range(255));
            repeat (150) send_coord(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        running = 1'b1;
        test_corners();
        test_octave_counts();
        test_persistence_and_seed();
        test_random(0, 0);
        test_random(56, 0);
        test_random(0, 56);
        test_random(15, 15);
        drain();
        $display("covered %0d coordinate transfers, %0d results checked", sent_count,
                 checked_count);
        $display("octave counts 0..15, persistence and seed extremes, four idle phases");
        if (error_count == 0)
        begin
            $display("octave_value_noise_2d verification clean");
        end
        else
        begin
            $display("octave_value_noise_2d verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ovn2d_pkg.sv
sv/ovn2d_hash.sv
sv/ovn2d_lanes.sv
sv/octave_value_noise_2d.sv
bench/octave_value_noise_2d_tb.sv
